// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: constants, command codes, state type.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int unsigned FieldW   = 32;
    localparam int unsigned CmdW     = 4;
    localparam int unsigned InDataW  = 136;
    localparam int unsigned OutDataW = 72;

    localparam logic [CmdW-1:0] CMD_ADD = 4'd0;
    localparam logic [CmdW-1:0] CMD_SUB = 4'd1;
    localparam logic [CmdW-1:0] CMD_MUL = 4'd2;
    localparam logic [CmdW-1:0] CMD_DIV = 4'd3;
    localparam logic [CmdW-1:0] CMD_GT  = 4'd4;
    localparam logic [CmdW-1:0] CMD_GE  = 4'd5;
    localparam logic [CmdW-1:0] CMD_LT  = 4'd6;
    localparam logic [CmdW-1:0] CMD_LE  = 4'd7;
    localparam logic [CmdW-1:0] CMD_EQ  = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_NSTART,
        ST_GSH,
        ST_GU,
        ST_GV,
        ST_GSUB,
        ST_DIVN,
        ST_DIVD,
        ST_NEND,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level: sequenced rational arithmetic with serial multiply, binary GCD and serial divide.
`timescale 1ns / 1ps
`default_nettype none
//  channel | dir | tdata fields (lowest bit up)
//  s       | in  | cmd[3:0] num_a[35:4] den_a[67:36] num_b[99:68] den_b[131:100], zero pad
//  m       | out | res_num[31:0] res_den[63:32] flag[64], zero pad to 72
//
//  One beat in, one beat out. Products come from a serial shift-add multiply: two for compares, mul
//  and div, three for add/sub (none when the denominators are equal), none for eq. The binary GCD
//  is followed by two serial divisions, numerator then denominator, when it exceeds one; eq
//  normalises twice. Reset is synchronous, active low, and clears the sequencer and output
//  valid. o_s_tready is high only in idle; a finished result waits in the output register while
//  the next beat is taken.
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // cmd, num_a, den_a, num_b, den_b, pad
    input  wire  [rau_pkg::InDataW-1:0]      i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // res_num, res_den, flag, pad
    output logic [rau_pkg::OutDataW-1:0]     o_m_tdata
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int SW = $clog2(WIDTH);
    localparam int FW = rau_pkg::FieldW;

    rau_pkg::t_state r_state, n_state;

    logic [3:0]       r_cmd, n_cmd;
    logic [WIDTH-1:0] r_na, r_da, r_nb, r_db, n_na, n_da, n_nb, n_db;
    logic [WIDTH-1:0] r_p [4];
    logic [WIDTH-1:0] n_p [4];
    logic [1:0]       r_pi, n_pi;
    logic             r_busy, n_busy;
    logic [WIDTH-1:0] r_mx, r_my, r_acc, n_mx, n_my, n_acc;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_n, r_d, n_n, n_d;
    logic [WIDTH-1:0] r_en, r_ed, n_en, n_ed;
    logic             r_phase, n_phase;
    logic [WIDTH-1:0] r_u, r_v, r_g, n_u, n_v, n_g;
    logic [SW-1:0]    r_sh, n_sh;
    logic [WIDTH-1:0] r_q, r_rem, n_q, n_rem;
    logic             r_fl, n_fl;
    logic             r_ovalid, n_ovalid;
    logic [rau_pkg::OutDataW-1:0] r_odata, n_odata;

    // shared datapath
    logic [3:0]       w_need;
    logic [WIDTH-1:0] w_opx, w_opy, w_acc;
    logic             w_last;
    logic [WIDTH-1:0] w_lo, w_hi, w_diff, w_g;
    logic [WIDTH:0]   w_rem2, w_sub;
    logic             w_ge;
    logic [WIDTH-1:0] w_qn, w_remn;
    logic [WIDTH-1:0] w_nn, w_dd, w_mn, w_md;
    logic [WIDTH+FW-1:0] w_ina, w_ida, w_inb, w_idb, w_on, w_od;
    logic             w_deq;

    assign w_ina = {{WIDTH{i_s_tdata[35]}},  i_s_tdata[35:4]};
    assign w_ida = {{WIDTH{i_s_tdata[67]}},  i_s_tdata[67:36]};
    assign w_inb = {{WIDTH{i_s_tdata[99]}},  i_s_tdata[99:68]};
    assign w_idb = {{WIDTH{i_s_tdata[131]}}, i_s_tdata[131:100]};
    assign w_on  = {{FW{1'b0}}, r_n};
    assign w_od  = {{FW{1'b0}}, r_d};

    assign w_deq = (r_da == r_db);

    // which of the four products the command needs
    always_comb begin
        case (r_cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: w_need = w_deq ? 4'b0000 : 4'b0111;
            rau_pkg::CMD_MUL: w_need = 4'b1100;
            rau_pkg::CMD_DIV: w_need = 4'b1001;
            rau_pkg::CMD_GT, rau_pkg::CMD_GE,
            rau_pkg::CMD_LT, rau_pkg::CMD_LE: w_need = 4'b0011;
            default: w_need = 4'b0000;
        endcase
    end

    always_comb begin
        case (r_pi)
            2'd0: begin w_opx = r_na; w_opy = r_db; end
            2'd1: begin w_opx = r_nb; w_opy = r_da; end
            2'd2: begin w_opx = r_da; w_opy = r_db; end
            default: begin
                w_opx = (r_cmd == rau_pkg::CMD_DIV) ? r_da : r_na;
                w_opy = r_nb;
            end
        endcase
    end

    assign w_acc  = r_acc + (r_my[0] ? r_mx : '0);
    assign w_last = (r_cnt == CW'(WIDTH - 1));

    assign w_lo   = (r_u > r_v) ? r_v : r_u;
    assign w_hi   = (r_u > r_v) ? r_u : r_v;
    assign w_diff = w_hi - w_lo;
    assign w_g    = w_lo << r_sh;

    assign w_rem2 = {r_rem, r_q[WIDTH-1]};
    assign w_sub  = w_rem2 - {1'b0, r_g};
    assign w_ge   = (w_rem2 >= {1'b0, r_g});
    assign w_remn = w_ge ? w_sub[WIDTH-1:0] : w_rem2[WIDTH-1:0];
    assign w_qn   = {r_q[WIDTH-2:0], w_ge};

    // sign fix-up before GCD
    assign w_nn = r_d[WIDTH-1] ? (-r_n) : r_n;
    assign w_dd = r_d[WIDTH-1] ? (-r_d) : r_d;
    assign w_mn = w_nn[WIDTH-1] ? (-w_nn) : w_nn;
    assign w_md = w_dd[WIDTH-1] ? (-w_dd) : w_dd;

    assign o_s_tready = (r_state == rau_pkg::ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE: if (i_s_tvalid) n_state = rau_pkg::ST_MUL;
            rau_pkg::ST_MUL: begin
                if ((!w_need[r_pi] || (r_busy && w_last)) && r_pi == 2'd3)
                    n_state = rau_pkg::ST_FORM;
            end
            rau_pkg::ST_FORM: begin
                case (r_cmd)
                    rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL,
                    rau_pkg::CMD_DIV, rau_pkg::CMD_EQ: n_state = rau_pkg::ST_NSTART;
                    default: n_state = rau_pkg::ST_DONE;
                endcase
            end
            rau_pkg::ST_NSTART: begin
                if (r_d == '0 || r_n == '0) n_state = rau_pkg::ST_NEND;
                else                        n_state = rau_pkg::ST_GSH;
            end
            rau_pkg::ST_GSH: if (r_u[0] || r_v[0]) n_state = rau_pkg::ST_GU;
            rau_pkg::ST_GU:  if (r_u[0]) n_state = rau_pkg::ST_GV;
            rau_pkg::ST_GV:  if (r_v[0]) n_state = rau_pkg::ST_GSUB;
            rau_pkg::ST_GSUB: begin
                if (w_diff != '0)    n_state = rau_pkg::ST_GV;
                else if (w_g > WIDTH'(1)) n_state = rau_pkg::ST_DIVN;
                else                 n_state = rau_pkg::ST_NEND;
            end
            rau_pkg::ST_DIVN: if (w_last) n_state = rau_pkg::ST_DIVD;
            rau_pkg::ST_DIVD: if (w_last) n_state = rau_pkg::ST_NEND;
            rau_pkg::ST_NEND: begin
                if (r_cmd == rau_pkg::CMD_EQ && !r_phase) n_state = rau_pkg::ST_NSTART;
                else                                       n_state = rau_pkg::ST_DONE;
            end
            rau_pkg::ST_DONE: if (!r_ovalid || i_m_tready) n_state = rau_pkg::ST_IDLE;
            default: n_state = rau_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd = r_cmd; n_na = r_na; n_da = r_da; n_nb = r_nb; n_db = r_db;
        n_p = r_p; n_pi = r_pi; n_busy = r_busy;
        n_mx = r_mx; n_my = r_my; n_acc = r_acc; n_cnt = r_cnt;
        n_n = r_n; n_d = r_d; n_en = r_en; n_ed = r_ed; n_phase = r_phase;
        n_u = r_u; n_v = r_v; n_g = r_g; n_sh = r_sh;
        n_q = r_q; n_rem = r_rem; n_fl = r_fl;
        n_ovalid = r_ovalid & ~i_m_tready;
        n_odata  = r_odata;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd = i_s_tdata[3:0];
                    n_na = w_ina[WIDTH-1:0]; n_da = w_ida[WIDTH-1:0];
                    n_nb = w_inb[WIDTH-1:0]; n_db = w_idb[WIDTH-1:0];
                    n_pi = 2'd0; n_busy = 1'b0; n_phase = 1'b0; n_fl = 1'b0;
                end
            end
            rau_pkg::ST_MUL: begin
                if (!w_need[r_pi]) begin
                    n_pi = r_pi + 2'd1;
                end else if (!r_busy) begin
                    n_busy = 1'b1; n_mx = w_opx; n_my = w_opy;
                    n_acc = '0; n_cnt = '0;
                end else begin
                    n_acc = w_acc; n_mx = r_mx << 1; n_my = r_my >> 1;
                    n_cnt = r_cnt + CW'(1);
                    if (w_last) begin
                        n_p[r_pi] = w_acc; n_busy = 1'b0; n_pi = r_pi + 2'd1;
                    end
                end
            end
            rau_pkg::ST_FORM: begin
                n_n = '0; n_d = WIDTH'(1);
                case (r_cmd)
                    rau_pkg::CMD_ADD: begin
                        n_d = w_deq ? r_da : r_p[2];
                        n_n = w_deq ? (r_na + r_nb) : (r_p[0] + r_p[1]);
                    end
                    rau_pkg::CMD_SUB: begin
                        n_d = w_deq ? r_da : r_p[2];
                        n_n = w_deq ? (r_na - r_nb) : (r_p[0] - r_p[1]);
                    end
                    rau_pkg::CMD_MUL: begin n_n = r_p[3]; n_d = r_p[2]; end
                    rau_pkg::CMD_DIV: begin n_n = r_p[0]; n_d = r_p[3]; end
                    rau_pkg::CMD_GT: n_fl = ($signed(r_p[0]) >  $signed(r_p[1]));
                    rau_pkg::CMD_GE: n_fl = ($signed(r_p[0]) >= $signed(r_p[1]));
                    rau_pkg::CMD_LT: n_fl = ($signed(r_p[0]) <  $signed(r_p[1]));
                    rau_pkg::CMD_LE: n_fl = ($signed(r_p[0]) <= $signed(r_p[1]));
                    rau_pkg::CMD_EQ: begin n_n = r_na; n_d = r_da; end
                    default: ;
                endcase
            end
            rau_pkg::ST_NSTART: begin
                if (r_d == '0) begin
                    n_n = '1;
                end else if (r_n == '0) begin
                    n_d = WIDTH'(1);
                end else begin
                    n_n = w_nn; n_d = w_dd; n_u = w_mn; n_v = w_md; n_sh = '0;
                end
            end
            rau_pkg::ST_GSH: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1; n_v = r_v >> 1; n_sh = r_sh + SW'(1);
                end
            end
            rau_pkg::ST_GU: if (!r_u[0]) n_u = r_u >> 1;
            rau_pkg::ST_GV: if (!r_v[0]) n_v = r_v >> 1;
            rau_pkg::ST_GSUB: begin
                n_u = w_lo; n_v = w_diff; n_g = w_g;
                n_q = r_n[WIDTH-1] ? (-r_n) : r_n;
                n_rem = '0; n_cnt = '0;
            end
            rau_pkg::ST_DIVN: begin
                n_q = w_qn; n_rem = w_remn; n_cnt = r_cnt + CW'(1);
                if (w_last) begin
                    n_n = r_n[WIDTH-1] ? (-w_qn) : w_qn;
                    n_q = r_d[WIDTH-1] ? (-r_d) : r_d;
                    n_rem = '0; n_cnt = '0;
                end
            end
            rau_pkg::ST_DIVD: begin
                n_q = w_qn; n_rem = w_remn; n_cnt = r_cnt + CW'(1);
                if (w_last) n_d = r_d[WIDTH-1] ? (-w_qn) : w_qn;
            end
            rau_pkg::ST_NEND: begin
                if (r_cmd == rau_pkg::CMD_EQ) begin
                    if (!r_phase) begin
                        n_en = r_n; n_ed = r_d; n_n = r_nb; n_d = r_db; n_phase = 1'b1;
                    end else begin
                        n_fl = (r_n == r_en) && (r_d == r_ed);
                        n_n = '0; n_d = WIDTH'(1);
                    end
                end
            end
            rau_pkg::ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {7'b0, r_fl, w_od[FW-1:0], w_on[FW-1:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rau_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_busy   <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_na <= n_na; r_da <= n_da; r_nb <= n_nb; r_db <= n_db;
        r_p <= n_p; r_pi <= n_pi;
        r_mx <= n_mx; r_my <= n_my; r_acc <= n_acc; r_cnt <= n_cnt;
        r_n <= n_n; r_d <= n_d; r_en <= n_en; r_ed <= n_ed; r_phase <= n_phase;
        r_u <= n_u; r_v <= n_v; r_g <= n_g; r_sh <= n_sh;
        r_q <= n_q; r_rem <= n_rem; r_fl <= n_fl;
        r_odata <= n_odata;
    end

endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_s_tvalid,
    input wire                          o_s_tready,
    input wire [rau_pkg::InDataW-1:0]   i_s_tdata,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [rau_pkg::OutDataW-1:0]  o_m_tdata
);

    // sequencer busy after a beat is taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready held after input beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output beat changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[71:65] == 7'd0))
        else $error("output pad bits set");

    // a set flag only comes from a compare, which returns 0/1
    a_flag_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[64]) |->
            (o_m_tdata[31:0] == 32'd0 && o_m_tdata[63:32] == 32'd1))
        else $error("flag with non-trivial fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== dv/tb_rational_arithmetic_unit.sv =====
// Testbench for the rational arithmetic unit: directed table, random beats, self-checking.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_arithmetic_unit;

    localparam int WatchdogLimit = 20000;
    localparam int RandomBeats   = 450;

    typedef struct packed {
        logic [rau_pkg::CmdW-1:0] cmd;
        logic [31:0]     na;
        logic [31:0]     da;
        logic [31:0]     nb;
        logic [31:0]     db;
    } t_req;

    typedef struct packed {
        logic [31:0] rn;
        logic [31:0] rd;
        logic        fl;
    } t_res;

    // directed row: operands, optional typed-in result
    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [rau_pkg::InDataW-1:0]   i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [rau_pkg::OutDataW-1:0]  o_m_tdata;

    rational_arithmetic_unit #(.WIDTH(32)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_res   pending_results[$];
    int     mismatches;
    int     idle_cycles;
    int     send_idle_pct;
    int     stall_pct;
    bit     hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [31:0] neg32(logic [31:0] x);
        return ~x + 32'd1;
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? neg32(x) : x;
    endfunction

    function automatic logic [31:0] bin_gcd(logic [31:0] u, logic [31:0] v);
        int sh;
        logic [31:0] t;
        sh = 0;
        if (u == 0) return v;
        if (v == 0) return u;
        while (((u | v) & 1) == 0) begin
            u = u >> 1; v = v >> 1; sh++;
        end
        while (u[0] == 1'b0) u = u >> 1;
        do begin
            while (v[0] == 1'b0) v = v >> 1;
            if (u > v) begin
                t = u; u = v; v = t;
            end
            v = v - u;
        end while (v != 0);
        return u << sh;
    endfunction

    function automatic logic [31:0] div_trunc(logic [31:0] x, logic [31:0] g);
        logic [31:0] q;
        q = mag32(x) / g;
        return x[31] ? neg32(q) : q;
    endfunction

    function automatic void reduce_frac(inout logic [31:0] n, inout logic [31:0] d);
        logic [31:0] g;
        if (d == 0) begin
            n = 32'hFFFF_FFFF;
            return;
        end
        if (n == 0) begin
            d = 32'd1;
            return;
        end
        if (d[31]) begin
            d = neg32(d); n = neg32(n);
        end
        g = bin_gcd(mag32(n), mag32(d));
        if (g > 1) begin
            n = div_trunc(n, g); d = div_trunc(d, g);
        end
    endfunction

    function automatic t_res predict_fraction(t_req q);
        t_res r;
        logic [31:0] l, rr, an, ad, bn, bd;
        l  = q.na * q.db;
        rr = q.nb * q.da;
        r  = '{rn: 32'd0, rd: 32'd1, fl: 1'b0};
        case (q.cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                if (q.da == q.db) begin
                    r.rd = q.da;
                    r.rn = (q.cmd == rau_pkg::CMD_ADD) ? q.na + q.nb : q.na - q.nb;
                end else begin
                    r.rd = q.da * q.db;
                    r.rn = (q.cmd == rau_pkg::CMD_ADD) ? l + rr : l - rr;
                end
                reduce_frac(r.rn, r.rd);
            end
            rau_pkg::CMD_MUL: begin
                r.rn = q.na * q.nb;
                r.rd = q.da * q.db;
                reduce_frac(r.rn, r.rd);
            end
            rau_pkg::CMD_DIV: begin
                r.rn = l;
                r.rd = q.da * q.nb;
                reduce_frac(r.rn, r.rd);
            end
            rau_pkg::CMD_GT: r.fl = $signed(l) >  $signed(rr);
            rau_pkg::CMD_GE: r.fl = $signed(l) >= $signed(rr);
            rau_pkg::CMD_LT: r.fl = $signed(l) <  $signed(rr);
            rau_pkg::CMD_LE: r.fl = $signed(l) <= $signed(rr);
            rau_pkg::CMD_EQ: begin
                an = q.na; ad = q.da; bn = q.nb; bd = q.db;
                reduce_frac(an, ad);
                reduce_frac(bn, bd);
                r.fl = (an == bn) && (ad == bd);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 40) - 20;
            6, 7: return $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    // one beat on the slave side, waits for acceptance; starts on a fresh falling edge
    task automatic send_beat(t_req q);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(rau_pkg::InDataW - $bits(t_req)){1'b0}},
                       q.db, q.nb, q.da, q.na, q.cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // expected values pushed at acceptance; directed rows push a typed-in value
    bit   next_known;
    t_res next_res;

    always @(posedge i_clk) begin
        t_req rq;
        rq.cmd = i_s_tdata[3:0];
        rq.na  = i_s_tdata[35:4];
        rq.da  = i_s_tdata[67:36];
        rq.nb  = i_s_tdata[99:68];
        rq.db  = i_s_tdata[131:100];
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (next_known)
                pending_results.push_back(next_res);
            else
                pending_results.push_back(predict_fraction(rq));
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{rn: o_m_tdata[31:0], rd: o_m_tdata[63:32], fl: o_m_tdata[64]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got.rn !== exp_r.rn || got.rd !== exp_r.rd || got.fl !== exp_r.fl) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp num %h den %h flag %b, got num %h den %h flag %b",
                                 exp_r.rn, exp_r.rd, exp_r.fl, got.rn, got.rd, got.fl);
                end
            end
        end
    end

    // receiver readiness
    always @(negedge i_clk) begin
        if (hold_off)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_req q;
        int   ph;
        int   n;
        mismatches    = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off      = 1'b0;
        next_known    = 1'b0;
        next_res      = '0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;

        // directed table
        rows.push_back('{'{rau_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd2}, 1,
                         '{32'd1, 32'd1, 1'b0}});
        rows.push_back('{'{rau_pkg::CMD_SUB, 32'd1, 32'd3, 32'd1, 32'd3}, 1,
                         '{32'd0, 32'd1, 1'b0}});
        rows.push_back('{'{rau_pkg::CMD_MUL, 32'd2, 32'd0, 32'd3, 32'd5}, 1,
                         '{32'hFFFF_FFFF, 32'd0, 1'b0}});
        rows.push_back('{'{rau_pkg::CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3}, 1,
                         '{32'hFFFF_FFFF, 32'd0, 1'b0}});
        // most negative denominator keeps its sign
        rows.push_back('{'{rau_pkg::CMD_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'd1}, 1,
                         '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0}});
        rows.push_back('{'{rau_pkg::CMD_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1}, 0,
                         '{0, 0, 0}});
        rows.push_back('{'{rau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd7}, 0,
                         '{0, 0, 0}});
        rows.push_back('{'{rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd2}, 0, '{0, 0, 0}});
        rows.push_back('{'{rau_pkg::CMD_DIV, 32'd6, 32'hFFFF_FFF8, 32'd9, 32'd4}, 0,
                         '{0, 0, 0}});
        rows.push_back('{'{rau_pkg::CMD_GT, 32'd1, 32'd2, 32'd1, 32'd3}, 1,
                         '{32'd0, 32'd1, 1'b1}});
        rows.push_back('{'{rau_pkg::CMD_GE, 32'd1, 32'd2, 32'd2, 32'd4}, 1,
                         '{32'd0, 32'd1, 1'b1}});
        rows.push_back('{'{rau_pkg::CMD_LT, 32'd1, 32'd2, 32'd1, 32'd3}, 1,
                         '{32'd0, 32'd1, 1'b0}});
        rows.push_back('{'{rau_pkg::CMD_LE, 32'd1, 32'd3, 32'd1, 32'd3}, 1,
                         '{32'd0, 32'd1, 1'b1}});
        rows.push_back('{'{rau_pkg::CMD_EQ, 32'd2, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE}, 1,
                         '{32'd0, 32'd1, 1'b1}});
        rows.push_back('{'{rau_pkg::CMD_EQ, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1}, 0,
                         '{0, 0, 0}});
        rows.push_back('{'{rau_pkg::CMD_GT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000}, 0, '{0, 0, 0}});
        rows.push_back('{'{4'd9, 32'd5, 32'd5, 32'd5, 32'd5}, 1, '{32'd0, 32'd1, 1'b0}});
        rows.push_back('{'{4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                         1, '{32'd0, 32'd1, 1'b0}});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            @(negedge i_clk);
            next_known = rows[k].known;
            next_res   = rows[k].res;
            send_beat(rows[k].req);
        end
        next_known = 1'b0;
        drain();

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int j = 0; j < 6; j++) begin
                    q = '{rau_pkg::CMD_ADD, rand_field(), rand_field(), rand_field(),
                          rand_field()};
                    send_beat(q);
                end
            end
        join
        drain();

        // random beats across idling phases
        n = RandomBeats / 4;
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 48 : 27) : 0;
            stall_pct     = (ph == 2 || ph == 3) ? ((ph == 2) ? 48 : 27) : 0;
            for (int j = 0; j < n; j++) begin
                q.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
                q.na = rand_field();
                q.da = rand_field();
                q.nb = rand_field();
                q.db = ($urandom_range(0, 3) == 0) ? q.da : rand_field();
                send_beat(q);
            end
        end
        drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
dv/tb_rational_arithmetic_unit.sv
